// ===== sv/v4alu_pkg.sv =====
`default_nettype none
package v4alu_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int EPS_W          = 31;
  localparam int OP_W           = 4;
  localparam int LANES          = 4;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd66;

  typedef enum logic [OP_W-1:0] {
    OP_EQ       = 4'd0,
    OP_ADD      = 4'd1,
    OP_SUB      = 4'd2,
    OP_NEG      = 4'd3,
    OP_SCALE    = 4'd4,
    OP_HADAMARD = 4'd5,
    OP_DIV      = 4'd6,
    OP_MAG      = 4'd7,
    OP_NORM     = 4'd8,
    OP_DOT      = 4'd9,
    OP_CROSS    = 4'd10
  } op_t;

endpackage
`default_nettype wire

// ===== sv/vec4_alu_core.sv =====
`default_nettype none
// Pipeline from input request to result (Q16.16 by default): multiply (loads at
//   the accepting edge), merge, one stage per root bit, one per quotient bit, then
//   the output register.
// Throughput: one request per cycle for every opcode; the pipeline holds only
//   while a result sits in the output register, the last stage is full and out_tready is low.
// Reset (rst_n low, synchronous): drops all requests in flight, clears the
//   output valid and sets epsilon to 66.
module vec4_alu_core #(
  parameter  int COMP_WIDTH = v4alu_pkg::COMP_WIDTH_DEF,
  parameter  int FRAC_BITS  = v4alu_pkg::FRAC_BITS_DEF,
  localparam int IN_BITS    = 9 * COMP_WIDTH,
  localparam int IN_DW      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 5 * COMP_WIDTH + 1,
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar (low to high)
  input  wire logic [IN_DW-1:0]               in_tdata,
  // req_type
  input  wire logic [v4alu_pkg::OP_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // res_x, res_y, res_z, res_w, scalar_out, equal_flag (low to high), zero pad
  output logic [OUT_DW-1:0]                   out_tdata,
  input  wire logic                           cfg_wr_en,
  input  wire logic [v4alu_pkg::EPS_W-1:0]    cfg_wr_data
);
  import v4alu_pkg::*;

  localparam int CW  = COMP_WIDTH;
  localparam int NW  = COMP_WIDTH + FRAC_BITS;
  localparam int P   = 2 + CW + NW;
  localparam int ZW  = (CW > EPS_W) ? CW : EPS_W;
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};

  // ---------------------------------------------------------------- control
  logic [EPS_W-1:0] eps_r;
  logic [P-1:0]     vld_r;
  logic             out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic             adv, out_load;

  // Hold the whole pipe only when the last stage has a result and the
  // output register cannot take it.
  assign adv       = !(vld_r[P-1] && out_valid_r && !out_tready);
  assign out_load  = vld_r[P-1] && (!out_valid_r || out_tready);
  assign in_tready = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= EPS_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if (adv) begin
        vld_r <= {vld_r[P-2:0], in_tvalid};
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ unpack and select
  op_t                 in_op;
  logic signed [CW-1:0] in_a [LANES];
  logic signed [CW-1:0] in_b [LANES];
  logic signed [CW-1:0] in_s;
  logic signed [CW-1:0] mx0 [LANES];
  logic signed [CW-1:0] my0 [LANES];
  logic signed [CW-1:0] mx1 [LANES];
  logic signed [CW-1:0] my1 [LANES];

  always_comb begin
    in_op = op_t'(in_tuser);
    for (int i = 0; i < LANES; i++) begin
      in_a[i] = in_tdata[i*CW +: CW];
      in_b[i] = in_tdata[(LANES+i)*CW +: CW];
    end
    in_s = in_tdata[2*LANES*CW +: CW];
    for (int i = 0; i < LANES; i++) begin
      mx0[i] = in_a[i];
      my0[i] = in_b[i];
      mx1[i] = '0;
      my1[i] = '0;
      case (in_op)
        OP_SCALE:         my0[i] = in_s;
        OP_MAG, OP_NORM:  my0[i] = in_a[i];
        default:          my0[i] = in_b[i];
      endcase
    end
    // cross product: lane i forms the two terms of component i
    if (in_op == OP_CROSS) begin
      mx0[0] = in_a[1]; my0[0] = in_b[2]; mx1[0] = in_a[2]; my1[0] = in_b[1];
      mx0[1] = in_a[2]; my0[1] = in_b[0]; mx1[1] = in_a[0]; my1[1] = in_b[2];
      mx0[2] = in_a[0]; my0[2] = in_b[1]; mx1[2] = in_a[1]; my1[2] = in_b[0];
      mx0[3] = '0;      my0[3] = '0;
    end
  end

  // ---------------------------------------------------------- stage 1 lanes
  logic signed [2*CW-1:0] p0 [LANES];
  logic signed [2*CW-1:0] p1 [LANES];
  logic signed [CW-1:0]   simple [LANES];
  logic                   near [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v4alu_lane #(.CW(CW)) u_lane (
      .clk      (clk),
      .adv      (adv),
      .op       (in_op),
      .a        (in_a[i]),
      .b        (in_b[i]),
      .x0       (mx0[i]),
      .y0       (my0[i]),
      .x1       (mx1[i]),
      .y1       (my1[i]),
      .eps      (eps_r),
      .p0_r     (p0[i]),
      .p1_r     (p1[i]),
      .simple_r (simple[i]),
      .near_r   (near[i])
    );
  end

  op_t                  op1_r, op2_r;
  logic signed [CW-1:0] a1_r [LANES];
  logic signed [CW-1:0] a2_r [LANES];
  logic signed [CW-1:0] s1_r, s2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_op;
      a1_r  <= in_a;
      s1_r  <= in_s;
      op2_r <= op1_r;
      a2_r  <= a1_r;
      s2_r  <= s1_r;
    end
  end

  // --------------------------------------------------------- stage 2 merge
  logic signed [CW-1:0] mr [LANES];
  logic signed [CW-1:0] msc;
  logic                 meq;
  logic [2*CW-1:0]      msq;

  v4alu_merge #(.CW(CW), .FB(FRAC_BITS)) u_merge (
    .clk    (clk),
    .adv    (adv),
    .op     (op1_r),
    .p0     (p0),
    .p1     (p1),
    .simple (simple),
    .near   (near),
    .r_r    (mr),
    .sc_r   (msc),
    .eq_r   (meq),
    .sq_r   (msq)
  );

  // ------------------------------------------------------------ square root
  logic [CW-1:0] root;

  v4alu_sqrt #(.CW(CW)) u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .sq   (msq),
    .root (root)
  );

  // advance the side data alongside the root stages
  op_t                  opq_r [CW];
  logic signed [CW-1:0] aq_r  [CW][LANES];
  logic signed [CW-1:0] sq_r  [CW];
  logic signed [CW-1:0] rq_r  [CW][LANES];
  logic signed [CW-1:0] scq_r [CW];
  logic                 eqq_r [CW];

  always_ff @(posedge clk) begin
    if (adv) begin
      opq_r[0] <= op2_r;
      aq_r[0]  <= a2_r;
      sq_r[0]  <= s2_r;
      rq_r[0]  <= mr;
      scq_r[0] <= msc;
      eqq_r[0] <= meq;
      for (int k = 1; k < CW; k++) begin
        opq_r[k] <= opq_r[k-1];
        aq_r[k]  <= aq_r[k-1];
        sq_r[k]  <= sq_r[k-1];
        rq_r[k]  <= rq_r[k-1];
        scq_r[k] <= scq_r[k-1];
        eqq_r[k] <= eqq_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------- division
  op_t                  opt;
  logic signed [CW-1:0] st;
  logic [CW-1:0]        den_mag;
  logic                 den_neg, den_zero;
  logic signed [CW-1:0] mag_sc;

  always_comb begin
    opt = opq_r[CW-1];
    st  = sq_r[CW-1];
    if (opt == OP_DIV) begin
      den_mag = st[CW-1] ? ({CW{1'b0}} - $unsigned(st)) : $unsigned(st);
      den_neg = st[CW-1];
    end else begin
      den_mag = root;
      den_neg = 1'b0;
    end
    // near-zero divisor or magnitude gives an all-zero vector
    den_zero = (den_mag == '0) || (ZW'(den_mag) < ZW'(eps_r));
    // magnitude is unsigned; clamp it to the signed range
    mag_sc = root[CW-1] ? SMAX : root;
  end

  logic signed [CW-1:0] quo [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_div
    v4alu_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
      .clk     (clk),
      .adv     (adv),
      .num     (aq_r[CW-1][i]),
      .den     (den_mag),
      .den_neg (den_neg),
      .zero    (den_zero),
      .quo     (quo[i])
    );
  end

  op_t                  opd_r   [NW];
  logic signed [CW-1:0] awd_r   [NW];
  logic                 zerod_r [NW];
  logic signed [CW-1:0] rd_r    [NW][LANES];
  logic signed [CW-1:0] scd_r   [NW];
  logic                 eqd_r   [NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      opd_r[0]   <= opt;
      awd_r[0]   <= aq_r[CW-1][3];
      zerod_r[0] <= den_zero;
      rd_r[0]    <= rq_r[CW-1];
      scd_r[0]   <= (opt == OP_MAG) ? mag_sc : scq_r[CW-1];
      eqd_r[0]   <= eqq_r[CW-1];
      for (int k = 1; k < NW; k++) begin
        opd_r[k]   <= opd_r[k-1];
        awd_r[k]   <= awd_r[k-1];
        zerod_r[k] <= zerod_r[k-1];
        rd_r[k]    <= rd_r[k-1];
        scd_r[k]   <= scd_r[k-1];
        eqd_r[k]   <= eqd_r[k-1];
      end
    end
  end

  // ----------------------------------------------------------- result pick
  logic signed [CW-1:0] res [LANES];
  logic [OUT_BITS-1:0]  res_pack;

  always_comb begin
    case (opd_r[NW-1])
      OP_DIV: begin
        res = quo;
      end
      OP_NORM: begin
        res    = quo;
        // w passes through unless the magnitude was near zero
        res[3] = zerod_r[NW-1] ? '0 : awd_r[NW-1];
      end
      default: begin
        res = rd_r[NW-1];
      end
    endcase
    res_pack = {eqd_r[NW-1], scd_r[NW-1], res[3], res[2], res[1], res[0]};
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DW'(res_pack);
    end
  end

  // ------------------------------------------------------------ assertions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("pipe held while output register empty");

  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P-1] && (!out_valid_r || out_tready) |=> out_valid_r)
    else $error("last stage result not moved to output");

  a_hold_keeps_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r[P-1])
    else $error("held result lost from last stage");

  a_eq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[OUT_BITS-1] |-> out_data_r[OUT_BITS-2:0] == '0)
    else $error("equal flag with nonzero vector or scalar");

endmodule
`default_nettype wire

// ===== sv/v4alu_lane.sv =====
`default_nettype none
module v4alu_lane #(
  parameter int CW = v4alu_pkg::COMP_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire v4alu_pkg::op_t                op,
  input  wire logic signed [CW-1:0]          a,
  input  wire logic signed [CW-1:0]          b,
  input  wire logic signed [CW-1:0]          x0,
  input  wire logic signed [CW-1:0]          y0,
  input  wire logic signed [CW-1:0]          x1,
  input  wire logic signed [CW-1:0]          y1,
  input  wire logic [v4alu_pkg::EPS_W-1:0]   eps,
  output logic signed [2*CW-1:0]             p0_r,
  output logic signed [2*CW-1:0]             p1_r,
  output logic signed [CW-1:0]               simple_r,
  output logic                               near_r
);
  import v4alu_pkg::*;

  localparam int CMP_W = (CW + 1 > EPS_W) ? CW + 1 : EPS_W;
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW:0] sum_w, diff_w, neg_w, pick_w, dmag;
  logic signed [CW-1:0] simple_nxt;
  logic near_nxt;

  always_comb begin
    sum_w  = {a[CW-1], a} + {b[CW-1], b};
    diff_w = {a[CW-1], a} - {b[CW-1], b};
    neg_w  = {(CW+1){1'b0}} - {a[CW-1], a};
    dmag   = diff_w[CW] ? ({(CW+1){1'b0}} - diff_w) : diff_w;
    case (op)
      OP_ADD:  pick_w = sum_w;
      OP_SUB:  pick_w = diff_w;
      OP_NEG:  pick_w = neg_w;
      default: pick_w = '0;
    endcase
    // saturate when the carry-out disagrees with the sign
    if (pick_w[CW] != pick_w[CW-1]) begin
      simple_nxt = pick_w[CW] ? SMIN : SMAX;
    end else begin
      simple_nxt = pick_w[CW-1:0];
    end
    near_nxt = CMP_W'(dmag) < CMP_W'(eps);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r     <= x0 * y0;
      p1_r     <= x1 * y1;
      simple_r <= simple_nxt;
      near_r   <= near_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/v4alu_merge.sv =====
`default_nettype none
module v4alu_merge #(
  parameter int CW = v4alu_pkg::COMP_WIDTH_DEF,
  parameter int FB = v4alu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  adv,
  input  wire v4alu_pkg::op_t        op,
  input  wire logic signed [2*CW-1:0] p0 [v4alu_pkg::LANES],
  input  wire logic signed [2*CW-1:0] p1 [v4alu_pkg::LANES],
  input  wire logic signed [CW-1:0]   simple [v4alu_pkg::LANES],
  input  wire logic                   near [v4alu_pkg::LANES],
  output logic signed [CW-1:0]        r_r [v4alu_pkg::LANES],
  output logic signed [CW-1:0]        sc_r,
  output logic                        eq_r,
  output logic [2*CW-1:0]             sq_r
);
  import v4alu_pkg::*;

  localparam int WW = 2 * CW + 2;
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
    logic [WW-CW:0] hi;
    hi = v[WW-1:CW-1];
    if ((&hi) || !(|hi)) begin
      return v[CW-1:0];
    end
    return v[WW-1] ? SMIN : SMAX;
  endfunction

  logic signed [WW-1:0] e0 [LANES];
  logic signed [WW-1:0] e1 [LANES];
  logic signed [WW-1:0] msh [LANES];
  logic signed [WW-1:0] csh [LANES];
  logic signed [WW-1:0] dot_w, dot_sh;
  logic signed [CW-1:0] r_nxt [LANES];
  logic signed [CW-1:0] sc_nxt;
  logic eq_nxt;
  logic [2*CW-1:0] sq_nxt;

  always_comb begin
    dot_w = '0;
    for (int i = 0; i < LANES; i++) begin
      e0[i]  = $signed({{2{p0[i][2*CW-1]}}, p0[i]});
      e1[i]  = $signed({{2{p1[i][2*CW-1]}}, p1[i]});
      msh[i] = e0[i] >>> FB;
      csh[i] = (e0[i] - e1[i]) >>> FB;
      dot_w  = dot_w + e0[i];
    end
    dot_sh = dot_w >>> FB;
    for (int i = 0; i < LANES; i++) begin
      case (op)
        OP_ADD, OP_SUB, OP_NEG: r_nxt[i] = simple[i];
        OP_SCALE, OP_HADAMARD:  r_nxt[i] = sat(msh[i]);
        OP_CROSS:               r_nxt[i] = (i < 3) ? sat(csh[i]) : '0;
        default:                r_nxt[i] = '0;
      endcase
    end
    sc_nxt = (op == OP_DOT) ? sat(dot_sh) : '0;
    eq_nxt = (op == OP_EQ) && near[0] && near[1] && near[2] && near[3];
    // squares are nonnegative and three of them stay below 2^(2*CW)
    sq_nxt = $unsigned(p0[0]) + $unsigned(p0[1]) + $unsigned(p0[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r  <= r_nxt;
      sc_r <= sc_nxt;
      eq_r <= eq_nxt;
      sq_r <= sq_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/v4alu_sqrt.sv =====
`default_nettype none
module v4alu_sqrt #(
  parameter int CW = v4alu_pkg::COMP_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [2*CW-1:0] sq,
  output logic [CW-1:0]        root
);

  logic [CW+1:0]   rem_r  [CW];
  logic [CW-1:0]   root_r [CW];
  logic [2*CW-1:0] n_r    [CW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [CW+1:0]   rem_i, rem2, trial;
    logic [CW-1:0]   root_i;
    logic [2*CW-1:0] n_i;
    logic            take;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = sq;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign n_i    = n_r[k-1];
    end
    assign rem2  = {rem_i[CW-1:0], n_i[2*CW-1:2*CW-2]};
    assign trial = {root_i, 2'b01};
    assign take  = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= take ? (rem2 - trial) : rem2;
        root_r[k] <= {root_i[CW-2:0], take};
        n_r[k]    <= n_i << 2;
      end
    end
  end

  assign root = root_r[CW-1];

endmodule
`default_nettype wire

// ===== sv/v4alu_div.sv =====
`default_nettype none
module v4alu_div #(
  parameter int CW = v4alu_pkg::COMP_WIDTH_DEF,
  parameter int FB = v4alu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic signed [CW-1:0] num,
  input  wire logic [CW-1:0]        den,
  input  wire logic                 den_neg,
  input  wire logic                 zero,
  output logic signed [CW-1:0]      quo
);

  localparam int NW = CW + FB;
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  logic [CW-1:0] rem_r  [NW];
  logic [NW-1:0] q_r    [NW];
  logic [NW-1:0] n_r    [NW];
  logic [CW-1:0] d_r    [NW];
  logic          neg_r  [NW];
  logic          zero_r [NW];
  logic [CW-1:0] nmag;

  assign nmag = num[CW-1] ? ({CW{1'b0}} - $unsigned(num)) : $unsigned(num);

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [CW-1:0] rem_i, d_i;
    logic [NW-1:0] q_i, n_i;
    logic          neg_i, zero_i, take;
    logic [CW:0]   r2, rdiff;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign q_i    = '0;
      assign n_i    = {nmag, {FB{1'b0}}};
      assign d_i    = den;
      assign neg_i  = num[CW-1] ^ den_neg;
      assign zero_i = zero;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign q_i    = q_r[k-1];
      assign n_i    = n_r[k-1];
      assign d_i    = d_r[k-1];
      assign neg_i  = neg_r[k-1];
      assign zero_i = zero_r[k-1];
    end
    assign r2    = {rem_i, n_i[NW-1]};
    assign take  = r2 >= {1'b0, d_i};
    assign rdiff = r2 - {1'b0, d_i};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= take ? rdiff[CW-1:0] : r2[CW-1:0];
        q_r[k]    <= {q_i[NW-2:0], take};
        n_r[k]    <= n_i << 1;
        d_r[k]    <= d_i;
        neg_r[k]  <= neg_i;
        zero_r[k] <= zero_i;
      end
    end
  end

  logic [NW-1:0] qf;
  logic [FB:0]   hi;
  logic          pos_ok, neg_ok;

  always_comb begin
    qf     = q_r[NW-1];
    hi     = qf[NW-1:CW-1];
    pos_ok = (hi == '0);
    neg_ok = pos_ok || ((hi == (FB+1)'(1)) && (qf[CW-2:0] == '0));
    if (zero_r[NW-1]) begin
      quo = '0;
    end else if (neg_r[NW-1]) begin
      quo = neg_ok ? ({CW{1'b0}} - qf[CW-1:0]) : SMIN;
    end else begin
      quo = pos_ok ? qf[CW-1:0] : SMAX;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import v4alu_pkg::*;

  localparam int CW       = 32;
  localparam int FB       = 16;
  localparam int IN_DW    = 288;
  localparam int OUT_DW   = 168;
  localparam int LATENCY  = 2 + 2 * CW + FB;
  localparam int WATCHDOG = 20000;
  localparam logic signed [CW-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] SMIN = 32'sh80000000;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic [3:0] op;
    comp_t      ax, ay, az, aw, bx, by, bz, bw, s;
  } vec_req_t;

  typedef struct packed {
    comp_t rx, ry, rz, rw, sc;
    logic  eq;
  } vec_res_t;

  // Directed row: request plus optional typed-in answer.
  typedef struct {
    vec_req_t req;
    bit       has_ans;
    vec_res_t ans;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [OP_W-1:0]  in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic             cfg_wr_en = 1'b0;
  logic [EPS_W-1:0] cfg_wr_data = '0;

  always #5 clk = ~clk;

  vec4_alu_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Predictor's own copy of the tolerance register.
  logic [EPS_W-1:0] eps_q = EPS_RESET;

  vec_res_t pending_res[$];
  int  n_fail = 0, n_req = 0, n_res = 0, idle_cycles = 0;
  bit  rx_no_idle = 0, tx_no_idle = 0, rx_hold = 0;
  int  op_seen[16];

  // ---------------- predictor ----------------
  function automatic comp_t sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return SMAX;
    if (v < -128'sd2147483648) return SMIN;
    return comp_t'(v);
  endfunction

  function automatic logic signed [127:0] wmul(comp_t a, comp_t b);
    logic signed [127:0] x, y;
    x = a; y = b;
    return x * y;
  endfunction

  // Shift right arithmetic: floor rounding.
  function automatic comp_t fxmul(comp_t a, comp_t b);
    return sat(wmul(a, b) >>> FB);
  endfunction

  // Quotient rounds toward zero.
  function automatic comp_t fxdiv(logic signed [127:0] num, logic signed [127:0] den);
    logic [127:0] n, d, q;
    logic signed [127:0] sq;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n << FB) / d;
    sq = q;
    return sat(((num < 0) != (den < 0)) ? -sq : sq);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] absdiff(comp_t a, comp_t b);
    logic signed [63:0] d;
    d = 64'(a) - 64'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic vec_res_t vec_predict(vec_req_t q);
    vec_res_t r;
    comp_t a[4], b[4];
    logic [63:0] m;
    logic signed [127:0] acc;
    r = '0;
    a = '{q.ax, q.ay, q.az, q.aw};
    b = '{q.bx, q.by, q.bz, q.bw};
    case (q.op)
      OP_EQ: begin
        r.eq = 1'b1;
        for (int i = 0; i < 4; i++)
          if (absdiff(a[i], b[i]) >= 64'(eps_q)) r.eq = 1'b0;
      end
      OP_ADD: begin
        r.rx = sat(a[0] + 128'(b[0])); r.ry = sat(a[1] + 128'(b[1]));
        r.rz = sat(a[2] + 128'(b[2])); r.rw = sat(a[3] + 128'(b[3]));
      end
      OP_SUB: begin
        r.rx = sat(a[0] - 128'(b[0])); r.ry = sat(a[1] - 128'(b[1]));
        r.rz = sat(a[2] - 128'(b[2])); r.rw = sat(a[3] - 128'(b[3]));
      end
      OP_NEG: begin
        r.rx = sat(-128'(a[0])); r.ry = sat(-128'(a[1]));
        r.rz = sat(-128'(a[2])); r.rw = sat(-128'(a[3]));
      end
      OP_SCALE: begin
        r.rx = fxmul(a[0], q.s); r.ry = fxmul(a[1], q.s);
        r.rz = fxmul(a[2], q.s); r.rw = fxmul(a[3], q.s);
      end
      OP_HADAMARD: begin
        r.rx = fxmul(a[0], b[0]); r.ry = fxmul(a[1], b[1]);
        r.rz = fxmul(a[2], b[2]); r.rw = fxmul(a[3], b[3]);
      end
      OP_DIV: begin
        if (q.s != 0 && absdiff(q.s, 0) >= 64'(eps_q)) begin
          r.rx = fxdiv(a[0], q.s); r.ry = fxdiv(a[1], q.s);
          r.rz = fxdiv(a[2], q.s); r.rw = fxdiv(a[3], q.s);
        end
      end
      OP_MAG, OP_NORM: begin
        m = isqrt(wmul(a[0], a[0]) + wmul(a[1], a[1]) + wmul(a[2], a[2]));
        if (q.op == OP_MAG) r.sc = sat(128'(m));
        else if (m != 0 && m >= 64'(eps_q)) begin
          r.rx = fxdiv(a[0], 128'(m)); r.ry = fxdiv(a[1], 128'(m));
          r.rz = fxdiv(a[2], 128'(m)); r.rw = a[3];
        end
      end
      OP_DOT: begin
        acc = wmul(a[0], b[0]) + wmul(a[1], b[1]) + wmul(a[2], b[2]) + wmul(a[3], b[3]);
        r.sc = sat(acc >>> FB);
      end
      OP_CROSS: begin
        r.rx = sat((wmul(a[1], b[2]) - wmul(a[2], b[1])) >>> FB);
        r.ry = sat((wmul(a[2], b[0]) - wmul(a[0], b[2])) >>> FB);
        r.rz = sat((wmul(a[0], b[1]) - wmul(a[1], b[0])) >>> FB);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- request side ----------------
  function automatic logic [IN_DW-1:0] pack_req(vec_req_t q);
    return {q.s, q.bw, q.bz, q.by, q.bx, q.aw, q.az, q.ay, q.ax};
  endfunction

  // Offer one request; hold it until accepted. Expected result pushed at accept.
  task automatic send_req(vec_req_t q, bit has_ans = 0, vec_res_t ans = '0);
    while (!tx_no_idle && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_req(q);
    in_tuser  <= q.op;
    do @(posedge clk); while (!in_tready);
    pending_res.push_back(has_ans ? ans : vec_predict(q));
    op_seen[q.op]++;
    n_req++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_eps(logic [EPS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    eps_q = v;
  endtask

  // Component picker: biased toward edges and small magnitudes.
  function automatic comp_t rnd_comp();
    case ($urandom_range(9))
      0: return SMAX;
      1: return SMIN;
      2: return 0;
      3, 4: return comp_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      5: return comp_t'($signed($urandom_range(0, 32'hffffff)) - 32'sh800000);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic vec_req_t rnd_req();
    vec_req_t q;
    q.op = ($urandom_range(19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    q.ax = rnd_comp(); q.ay = rnd_comp(); q.az = rnd_comp(); q.aw = rnd_comp();
    q.bx = rnd_comp(); q.by = rnd_comp(); q.bz = rnd_comp(); q.bw = rnd_comp();
    q.s  = rnd_comp();
    // Near-equal vectors so the equality test passes now and then.
    if (q.op == OP_EQ && $urandom_range(1)) begin
      q.bx = q.ax + $signed($urandom_range(0, 140)) - 70;
      q.by = q.ay + $signed($urandom_range(0, 140)) - 70;
      q.bz = q.az + $signed($urandom_range(0, 140)) - 70;
      q.bw = q.aw + $signed($urandom_range(0, 140)) - 70;
    end
    if (q.op == OP_DIV && $urandom_range(3) == 0)
      q.s = $signed($urandom_range(0, 200)) - 100;
    return q;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      vec_res_t got, exp_r;
      got = vec_res_t'({out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
                        out_tdata[127:96], out_tdata[159:128], out_tdata[160]});
      n_res++;
      if (pending_res.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        n_fail++;
      end else begin
        exp_r = pending_res.pop_front();
        if (got.rx !== exp_r.rx) begin
          $error("res_x exp %h got %h", exp_r.rx, got.rx); n_fail++;
        end
        if (got.ry !== exp_r.ry) begin
          $error("res_y exp %h got %h", exp_r.ry, got.ry); n_fail++;
        end
        if (got.rz !== exp_r.rz) begin
          $error("res_z exp %h got %h", exp_r.rz, got.rz); n_fail++;
        end
        if (got.rw !== exp_r.rw) begin
          $error("res_w exp %h got %h", exp_r.rw, got.rw); n_fail++;
        end
        if (got.sc !== exp_r.sc) begin
          $error("scalar_out exp %h got %h", exp_r.sc, got.sc); n_fail++;
        end
        if (got.eq !== exp_r.eq) begin
          $error("equal_flag exp %b got %b", exp_r.eq, got.eq); n_fail++;
        end
      end
    end
  end

  // Receiver: random stall, or a long counted hold-off on request.
  always @(posedge clk) begin
    if (rx_hold) out_tready <= 1'b0;
    else out_tready <= rx_no_idle || ($urandom_range(99) >= 23);
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired with %0d results pending", pending_res.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic vec_req_t mk(op_t op, comp_t ax, comp_t ay, comp_t az, comp_t aw,
                                  comp_t bx, comp_t by, comp_t bz, comp_t bw, comp_t s);
    vec_req_t q;
    q = '{op, ax, ay, az, aw, bx, by, bz, bw, s};
    return q;
  endfunction

  function automatic vec_res_t rv(comp_t x, comp_t y, comp_t z, comp_t w,
                                  comp_t sc, logic eq);
    vec_res_t r;
    r = '{x, y, z, w, sc, eq};
    return r;
  endfunction

  localparam comp_t ONE = 32'sh10000;

  row_t dir_rows[$];

  initial begin
    vec_req_t q;
    logic [EPS_W-1:0] eps_tab[5];
    dir_rows = '{
      // equality at the default tolerance: differ by 65 passes, by 66 fails
      '{mk(OP_EQ, 0, 0, 0, 0, 65, -65, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 1)},
      '{mk(OP_EQ, 0, 0, 0, 0, 66, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 0)},
      '{mk(OP_EQ, SMAX, 0, 0, 0, SMIN, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 0)},
      // add/sub saturate at both ends
      '{mk(OP_ADD, SMAX, SMIN, 1, -1, 1, -1, 2, -2, 0), 1, rv(SMAX, SMIN, 3, -3, 0, 0)},
      '{mk(OP_SUB, SMIN, SMAX, 5, 0, 1, -1, 7, 0, 0), 1, rv(SMIN, SMAX, -2, 0, 0, 0)},
      '{mk(OP_NEG, SMIN, SMAX, 0, 1, 0, 0, 0, 0, 0), 1, rv(SMAX, -SMAX, 0, -1, 0, 0)},
      '{mk(OP_SCALE, ONE, -ONE, SMAX, 3, 0, 0, 0, 0, 2 * ONE), 1,
        rv(2 * ONE, -2 * ONE, SMAX, 6, 0, 0)},
      '{mk(OP_SCALE, -1, 1, SMIN, SMIN, 0, 0, 0, 0, 1), 0, '0},
      '{mk(OP_HADAMARD, ONE, 2 * ONE, 3 * ONE, 4 * ONE, ONE, ONE, -ONE, 2 * ONE, 0), 1,
        rv(ONE, 2 * ONE, -3 * ONE, 8 * ONE, 0, 0)},
      // divide by zero and near zero give zeros
      '{mk(OP_DIV, ONE, ONE, ONE, ONE, 0, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 0)},
      '{mk(OP_DIV, ONE, ONE, ONE, ONE, 0, 0, 0, 0, -65), 1, rv(0, 0, 0, 0, 0, 0)},
      '{mk(OP_DIV, ONE, -ONE, SMAX, SMIN, 0, 0, 0, 0, 66), 0, '0},
      '{mk(OP_DIV, 4 * ONE, -4 * ONE, 0, 1, 0, 0, 0, 0, 2 * ONE), 1,
        rv(2 * ONE, -2 * ONE, 0, 0, 0, 0)},
      '{mk(OP_MAG, 3 * ONE, 4 * ONE, 0, 9, 0, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 5 * ONE, 0)},
      '{mk(OP_MAG, SMIN, SMIN, SMIN, 0, 0, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, SMAX, 0)},
      '{mk(OP_NORM, 3 * ONE, 0, 4 * ONE, 7, 0, 0, 0, 0, 0), 0, '0},
      // tiny magnitude: everything zero, w too
      '{mk(OP_NORM, 1, 1, 1, 77, 0, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 0)},
      '{mk(OP_NORM, 0, 0, 0, 5, 0, 0, 0, 0, 0), 1, rv(0, 0, 0, 0, 0, 0)},
      '{mk(OP_DOT, ONE, ONE, ONE, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0), 1,
        rv(0, 0, 0, 0, 10 * ONE, 0)},
      '{mk(OP_DOT, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0), 1,
        rv(0, 0, 0, 0, SMAX, 0)},
      '{mk(OP_CROSS, ONE, 0, 0, 9, 0, ONE, 0, 9, 0), 1, rv(0, 0, ONE, 0, 0, 0)},
      '{mk(OP_CROSS, SMAX, SMIN, SMAX, -1, SMIN, SMAX, SMIN, -1, 0), 0, '0}
    };
    eps_tab = '{31'd0, 31'd1, 31'h7fffffff, EPS_RESET, 31'd70000};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at reset tolerance, then one undefined opcode with all ones.
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_ans, dir_rows[i].ans);
    q = '1;
    send_req(q, 1, '0);
    drain_results();

    // Random phases across tolerance settings, extremes included.
    for (int k = 0; k < 5; k++) begin
      write_eps(eps_tab[k]);
      // No-idle stretch in the middle phase.
      tx_no_idle = (k == 2);
      rx_no_idle = (k == 2);
      for (int n = 0; n < 250; n++) begin
        // Long receiver hold-off while requests keep coming.
        if (k == 1 && n == 20) begin
          fork
            begin
              rx_hold = 1;
              repeat (300) @(posedge clk);
              rx_hold = 0;
            end
          join_none
        end
        // Sender pauses until every result is back.
        if (k == 3 && n == 125) drain_results();
        send_req(rnd_req());
      end
      drain_results();
    end

    $display("%0d requests, %0d results; ops seen eq..cross: %0d %0d %0d %0d %0d %0d",
             n_req, n_res, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5]);
    $display("  %0d %0d %0d %0d %0d; five tolerance settings, stalls and hold-off",
             op_seen[6], op_seen[7], op_seen[8], op_seen[9], op_seen[10]);
    if (n_fail == 0 && pending_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
